FILE: rtl/sha256_byte_stream_hasher_defines.svh
// Assertion helpers for the hasher
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: rtl/sha_pkg.sv
package sha_pkg;
   localparam int unsigned RoundCount = 64;
   localparam int unsigned BlockBytes = 64;
   localparam int unsigned LengthPos = 56;

   typedef logic [31:0] word_type;

   localparam word_type InitHash [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   // Byte source for a block write
   typedef enum logic [1:0] {
      BYTE_DATA, BYTE_PAD, BYTE_ZERO, BYTE_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         wr_en;
      logic [5:0]   wr_addr;
      byte_sel_type wr_sel;
      logic [7:0]   wr_data;
      logic         len_add;
      logic         start;
      logic         round;
      logic [5:0]   round_idx;
      logic         accum;
      logic         init;
      logic [2:0]   out_idx;
   } cmd_type;

   function automatic word_type rotr(word_type v, int unsigned n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction
endpackage

FILE: rtl/sha_stream_if.sv
interface sha_stream_if #(parameter int unsigned Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sha_datapath.sv
module sha_datapath (
   input  logic             clock,
   input  sha_pkg::cmd_type cmd,
   output logic [31:0]      digest_word
);
   logic [63:0] len_ff;
   sha_pkg::word_type h_ff [8];
   sha_pkg::word_type v_ff [8];
   sha_pkg::word_type w_ff [16];
   logic [7:0]  wbyte;
   logic [3:0]  rd_addr;
   sha_pkg::word_type w_new, t1, t2, s0, s1, w2, w15, wr;

   always_comb begin
      case (cmd.wr_sel)
         sha_pkg::BYTE_DATA: wbyte = cmd.wr_data;
         sha_pkg::BYTE_PAD:  wbyte = 8'h80;
         sha_pkg::BYTE_LEN:  wbyte = len_ff[8'(6'd63 - cmd.wr_addr) * 8 +: 8];
         default:            wbyte = 8'h00;
      endcase
   end

   // Block words are read as four bytes one round ahead: mem split by byte lane
   assign rd_addr = cmd.round ? 4'(cmd.round_idx + 6'd1) : cmd.round_idx[3:0];

   for (genvar g = 0; g < 4; g++) begin : g_lane
      logic [7:0] lane_mem [16];
      logic [7:0] rd_ff;
      always_ff @(posedge clock) begin
         if (cmd.wr_en && cmd.wr_addr[1:0] == 2'(g)) begin
            lane_mem[cmd.wr_addr[5:2]] <= wbyte;
         end
         rd_ff <= lane_mem[rd_addr];
      end
   end

   assign wr = {g_lane[0].rd_ff, g_lane[1].rd_ff, g_lane[2].rd_ff, g_lane[3].rd_ff};

   always_comb begin
      w2 = w_ff[4'(cmd.round_idx - 6'd2)];
      w15 = w_ff[4'(cmd.round_idx - 6'd15)];
      s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
      s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
      if (cmd.round_idx < 6'd16) begin
         w_new = wr;
      end else begin
         w_new = s1 + w_ff[4'(cmd.round_idx - 6'd7)] + s0 + w_ff[cmd.round_idx[3:0]];
      end
      t1 = v_ff[7] + (sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
         ^ sha_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha_pkg::RoundK[cmd.round_idx] + w_new;
      t2 = (sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
         ^ sha_pkg::rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         len_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha_pkg::InitHash[i];
      end else begin
         if (cmd.len_add) begin
            len_ff <= len_ff + 64'd8;
         end
         if (cmd.accum) begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end
      if (cmd.start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (cmd.round) begin
         w_ff[cmd.round_idx[3:0]] <= w_new;
         for (int i = 1; i < 8; i++) begin
            if (i != 4) v_ff[i] <= v_ff[i-1];
         end
         v_ff[4] <= v_ff[3] + t1;
         v_ff[0] <= t1 + t2;
      end
   end

   assign digest_word = h_ff[cmd.out_idx];
endmodule

FILE: rtl/sha_control.sv
module sha_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_byte,
   input  logic             in_bv,
   input  logic             in_eom,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [2:0]       out_idx,
   output sha_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_START, S_ROUND, S_ACCUM, S_FILL, S_EMIT
   } state_type;

   state_type   state_ff;
   logic [5:0]  cnt_ff;      // bytes in block
   logic [6:0]  rnd_ff;      // round counter, bit 6 = prefetch phase
   logic [5:0]  fill_ff;
   logic        pad_ff;      // padding pending (final item seen)
   logic        twoblk_ff;   // the second padding block (zeros and length, no pad byte) is being hashed
   logic        fin_ff;      // compression of the length block
   logic [2:0]  oidx_ff;
   logic        acc;

   assign acc = in_valid && in_ready;
   assign in_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_EMIT);
   assign out_idx = oidx_ff;

   always_comb begin
      cmd = '0;
      cmd.wr_sel = sha_pkg::BYTE_DATA;
      cmd.wr_data = in_byte;
      cmd.out_idx = oidx_ff;
      cmd.round_idx = rnd_ff[5:0];
      case (state_ff)
         S_IDLE: begin
            cmd.wr_en = acc && in_bv;
            cmd.wr_addr = cnt_ff;
            cmd.len_add = acc && in_bv;
         end
         S_FILL: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = fill_ff;
            if (fill_ff == cnt_ff && !twoblk_ff) begin
               cmd.wr_sel = sha_pkg::BYTE_PAD;
            end else if (fill_ff >= 6'(sha_pkg::LengthPos) && !(cnt_ff >= 6'd56
                         && !twoblk_ff)) begin
               cmd.wr_sel = sha_pkg::BYTE_LEN;
            end else if (fill_ff > cnt_ff || twoblk_ff) begin
               cmd.wr_sel = sha_pkg::BYTE_ZERO;
            end else begin
               cmd.wr_en = 1'b0;
            end
         end
         S_START: begin
            cmd.start = 1'b1;
         end
         S_ROUND: begin
            cmd.round = !rnd_ff[6];
         end
         S_ACCUM: cmd.accum = 1'b1;
         S_EMIT: cmd.init = out_ready && oidx_ff == 3'd7;
         default: ;
      endcase
      if (reset) cmd.init = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rnd_ff <= '0;
         fill_ff <= '0;
         pad_ff <= 1'b0;
         twoblk_ff <= 1'b0;
         fin_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: if (acc) begin
               if (in_bv) cnt_ff <= cnt_ff + 6'd1;
               pad_ff <= in_eom;
               if (in_bv && cnt_ff == 6'd63) begin
                  state_ff <= S_START;
                  twoblk_ff <= 1'b0;
                  fin_ff <= 1'b0;
               end else if (in_eom) begin
                  state_ff <= S_FILL;
                  fill_ff <= '0;
                  twoblk_ff <= 1'b0;
               end
            end
            S_FILL: begin
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == 6'd63) begin
                  state_ff <= S_START;
                  fin_ff <= !(cnt_ff >= 6'd56 && !twoblk_ff);
               end
            end
            S_START: begin
               state_ff <= S_ROUND;
               rnd_ff <= 7'h40;  // prefetch phase for the first word
            end
            S_ROUND: begin
               if (rnd_ff == 7'h40) rnd_ff <= 7'd0;
               else if (rnd_ff == 7'd63) state_ff <= S_ACCUM;
               else rnd_ff <= rnd_ff + 7'd1;
            end
            S_ACCUM: begin
               rnd_ff <= '0;
               if (fin_ff) begin
                  state_ff <= S_EMIT;
                  oidx_ff <= '0;
               end else if (pad_ff && !twoblk_ff && cnt_ff >= 6'd56) begin
                  twoblk_ff <= 1'b1;
                  fill_ff <= '0;
                  state_ff <= S_FILL;
               end else if (pad_ff) begin
                  // full block ended exactly at the final byte
                  twoblk_ff <= 1'b0;
                  fill_ff <= '0;
                  state_ff <= S_FILL;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_EMIT: if (out_ready) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  state_ff <= S_IDLE;
                  cnt_ff <= '0;
                  pad_ff <= 1'b0;
                  twoblk_ff <= 1'b0;
                  fin_ff <= 1'b0;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// A byte that fills a block starts a compression: load, one prefetch and 64 rounds,
// then accumulate; other bytes are only written, and the next byte can follow.
// Final item: a padding fill of the 64 block bytes and a compression, twice if 56 or more
// bytes were pending, then eight digest words, one per accepted cycle.
// The single round unit is shared by all blocks; no bytes are taken during a compression.
// Synchronous active-high reset restores the initial hash values; no clearing pass.
`include "sha256_byte_stream_hasher_defines.svh"
module sha256_byte_stream_hasher (
   input  logic clock,
   input  logic reset,
   sha_stream_if.sink   req,
   sha_stream_if.source rsp
);
   sha_pkg::cmd_type cmd;
   logic [31:0] word;
   logic [2:0]  idx;

   sha_control u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready),
      .in_byte(req.data[7:0]), .in_bv(req.data[8]), .in_eom(req.data[9]),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_idx(idx), .cmd(cmd));

   sha_datapath u_dp (.clock(clock), .cmd(cmd), .digest_word(word));

   assign rsp.data = {(idx == 3'd7), idx, word};

   `SHA_ASSERT_IMPL(a_no_overlap, clock, reset, rsp.valid, !req.ready)
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp.valid && rsp.ready && idx != 3'd7,
      rsp.valid && idx == $past(idx) + 3'd1)
endmodule
